// File: design/wmt_pkg.sv
// Shared types, constants and codes for the receive-waiter match table.
package wmt_pkg;

    localparam int SLOTS  = 8;
    localparam int SLOT_W = (SLOTS > 1) ? $clog2(SLOTS) : 1;
    localparam int CNT_W  = $clog2(SLOTS + 1);

    localparam logic [3:0] ACTIVE_RST = 4'd8;

    typedef enum logic [1:0] {
        CMD_ARM  = 2'd0,
        CMD_PKT  = 2'd1,
        CMD_POLL = 2'd2
    } cmd_t;

    typedef enum logic [2:0] {
        ST_ARMED   = 3'd0,
        ST_MATCHED = 3'd1,
        ST_MISSED  = 3'd2,
        ST_WAITING = 3'd3,
        ST_IDLE    = 3'd4
    } status_t;

    typedef enum logic [1:0] {
        S_IDLE,
        S_DISPATCH,
        S_EVAL,
        S_DONE
    } state_t;

    typedef struct packed {
        logic [1:0]  cmd;
        logic [2:0]  slot;
        logic [15:0] dest_port;
        logic [63:0] addr_high;
        logic [63:0] addr_low;
        logic [15:0] src_port;
        logic [15:0] capacity;
        logic [15:0] pkt_len;
        logic [63:0] now;
        logic [63:0] span;
    } req_t;

    typedef struct packed {
        status_t     status;
        logic [2:0]  hit_slot;
        logic [15:0] xfer_len;
        logic [63:0] from_addr_high;
        logic [63:0] from_addr_low;
        logic [15:0] from_port;
    } rsp_t;

    // One waiter record as held in the slot memory.
    typedef struct packed {
        logic [15:0] want_dport;
        logic [63:0] want_addr_high;
        logic [63:0] want_addr_low;
        logic [15:0] want_sport;
        logic [15:0] buf_cap;
        logic [63:0] start_time;
        logic [63:0] wait_span;
    } entry_t;

    typedef struct packed {
        logic              wr_en;
        logic [SLOT_W-1:0] wr_addr;
        logic              rd_en;
        logic [SLOT_W-1:0] rd_addr;
        logic              clr_wait;
        logic [SLOT_W-1:0] clr_addr;
    } store_ctrl_t;

    typedef struct packed {
        logic        hit;
        logic        timed_out;
        logic [15:0] xfer_len;
    } match_t;

endpackage

// File: design/wmt_store.sv
// Slot memory of waiter records plus the per-slot waiting flags.
module wmt_store
    import wmt_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  store_ctrl_t       ctrl,
    input  entry_t            wdata,
    output entry_t            rdata,
    output logic [SLOTS-1:0]  waiting
);

    entry_t           mem [SLOTS];
    entry_t           rdata_reg;
    logic [SLOTS-1:0] waiting_reg;
    logic [SLOTS-1:0] waiting_next;

    always_ff @(posedge clk)
    begin
        if (ctrl.wr_en)
        begin
            mem[ctrl.wr_addr] <= wdata;
        end
        if (ctrl.rd_en)
        begin
            rdata_reg <= mem[ctrl.rd_addr];
        end
    end

    // An arm marks its slot waiting; a match or a timeout clears it.
    always_comb
    begin
        waiting_next = waiting_reg;
        if (ctrl.wr_en)
        begin
            waiting_next[ctrl.wr_addr] = 1'b1;
        end
        if (ctrl.clr_wait)
        begin
            waiting_next[ctrl.clr_addr] = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            waiting_reg <= '0;
        end
        else
        begin
            waiting_reg <= waiting_next;
        end
    end

    assign rdata   = rdata_reg;
    assign waiting = waiting_reg;

endmodule

// File: design/wmt_match.sv
// Shared compare unit: wildcard filter match, copy length and timeout test.
module wmt_match
    import wmt_pkg::*;
(
    input  entry_t      entry,
    input  logic [15:0] dest_port,
    input  logic [63:0] addr_high,
    input  logic [63:0] addr_low,
    input  logic [15:0] src_port,
    input  logic [15:0] pkt_len,
    input  logic [63:0] now,
    output match_t      result
);

    logic        port_ok;
    logic        addr_ok;
    logic        sport_ok;
    logic [63:0] elapsed;

    // A zero filter value matches anything.
    assign port_ok  = (entry.want_dport == '0) || (entry.want_dport == dest_port);
    assign addr_ok  = ((entry.want_addr_high == '0) && (entry.want_addr_low == '0)) ||
                      ((entry.want_addr_high == addr_high) && (entry.want_addr_low == addr_low));
    assign sport_ok = (entry.want_sport == '0) || (entry.want_sport == src_port);

    assign elapsed = now - entry.start_time;

    assign result.hit       = port_ok && addr_ok && sport_ok;
    assign result.timed_out = (elapsed >= entry.wait_span);
    assign result.xfer_len  = (pkt_len < entry.buf_cap) ? pkt_len : entry.buf_cap;

endmodule

// File: design/udp_waiter_match_table.sv
// Top level of the receive-waiter match table: sequencer, config and result register.
//
// Each item on the req channel is one command: arm a slot with a waiter's
// filters, look up an arriving packet, or poll a slot for timeout. Every item
// yields exactly one result item on the rsp channel. Both channels use a
// valid/ready handshake; cfg_we writes the scan count active_slots at once.
//
// An item is worked on alone. Arm, unknown commands and out-of-range slots
// pass from acceptance through the dispatch and done states; a poll also
// passes through the evaluate state. A packet lookup reads one slot a cycle
// from the slot memory through the single compare unit, scanning slots up
// to the first match (at most min(active_slots, 8) of them). req_ready
// rises again in the same cycle as the result appears in the output
// register, so the next item is taken while that result waits.
//
// If the receiver stalls, the result stays in the output register; a
// following item is worked on, and its result waits until the register is
// taken. Reset clears all waiting flags and sets active_slots to 8; slot
// records are not cleared since a record is only used while its slot is waiting.
module udp_waiter_match_table
    import wmt_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       cfg_we,
    input  logic [3:0] cfg_wdata,
    input  logic       req_valid,
    output logic       req_ready,
    input  req_t       req,
    output logic       rsp_valid,
    input  logic       rsp_ready,
    output rsp_t       rsp
);

    state_t            state_reg, state_next;
    req_t              item_reg, item_next;
    rsp_t              res_reg, res_next;
    rsp_t              rsp_reg, rsp_next;
    logic              rsp_valid_reg, rsp_valid_next;
    logic [3:0]        active_reg;
    logic [CNT_W-1:0]  idx_reg, idx_next;
    logic [CNT_W-1:0]  limit_reg, limit_next;
    logic [CNT_W-1:0]  limit_calc;
    logic [CNT_W-1:0]  idx_inc;
    logic [SLOT_W-1:0] slot_idx;
    logic [SLOT_W-1:0] scan_idx;
    logic              slot_ok;
    store_ctrl_t       ctrl;
    entry_t            wdata;
    entry_t            rdata;
    logic [SLOTS-1:0]  waiting;
    match_t            mres;

    // The scan count is clamped to the table size.
    assign limit_calc = (32'(active_reg) > SLOTS) ? CNT_W'(SLOTS) : CNT_W'(active_reg);
    assign slot_ok    = (32'(item_reg.slot) < SLOTS);
    assign slot_idx   = SLOT_W'(item_reg.slot);
    assign scan_idx   = idx_reg[SLOT_W-1:0];
    assign idx_inc    = CNT_W'(idx_reg + 1'b1);

    assign wdata.want_dport     = item_reg.dest_port;
    assign wdata.want_addr_high = item_reg.addr_high;
    assign wdata.want_addr_low  = item_reg.addr_low;
    assign wdata.want_sport     = item_reg.src_port;
    assign wdata.buf_cap        = item_reg.capacity;
    assign wdata.start_time     = item_reg.now;
    assign wdata.wait_span      = item_reg.span;

    wmt_store u_store (
        .clk     (clk),
        .rst_n   (rst_n),
        .ctrl    (ctrl),
        .wdata   (wdata),
        .rdata   (rdata),
        .waiting (waiting)
    );

    wmt_match u_match (
        .entry     (rdata),
        .dest_port (item_reg.dest_port),
        .addr_high (item_reg.addr_high),
        .addr_low  (item_reg.addr_low),
        .src_port  (item_reg.src_port),
        .pkt_len   (item_reg.pkt_len),
        .now       (item_reg.now),
        .result    (mres)
    );

    assign req_ready = (state_reg == S_IDLE);
    assign rsp_valid = rsp_valid_reg;
    assign rsp       = rsp_reg;

    always_comb
    begin
        state_next     = state_reg;
        item_next      = item_reg;
        res_next       = res_reg;
        rsp_next       = rsp_reg;
        rsp_valid_next = rsp_valid_reg && !rsp_ready;
        idx_next       = idx_reg;
        limit_next     = limit_reg;
        ctrl           = '0;

        case (state_reg)
            S_IDLE:
            begin
                if (req_valid)
                begin
                    item_next  = req;
                    state_next = S_DISPATCH;
                end
            end

            S_DISPATCH:
            begin
                res_next          = '0;
                res_next.hit_slot = item_reg.slot;
                res_next.status   = ST_IDLE;
                state_next        = S_DONE;
                case (item_reg.cmd)
                    CMD_ARM:
                    begin
                        if (slot_ok)
                        begin
                            ctrl.wr_en      = 1'b1;
                            ctrl.wr_addr    = slot_idx;
                            res_next.status = ST_ARMED;
                        end
                    end
                    CMD_POLL:
                    begin
                        if (slot_ok)
                        begin
                            ctrl.rd_en   = 1'b1;
                            ctrl.rd_addr = slot_idx;
                            state_next   = S_EVAL;
                        end
                    end
                    CMD_PKT:
                    begin
                        res_next.hit_slot = '0;
                        limit_next        = limit_calc;
                        idx_next          = '0;
                        if (limit_calc == '0)
                        begin
                            res_next.status = ST_MISSED;
                        end
                        else
                        begin
                            ctrl.rd_en   = 1'b1;
                            ctrl.rd_addr = '0;
                            state_next   = S_EVAL;
                        end
                    end
                    default:
                    begin
                        res_next.hit_slot = '0;
                    end
                endcase
            end

            S_EVAL:
            begin
                if (item_reg.cmd == CMD_POLL)
                begin
                    state_next = S_DONE;
                    if (waiting[slot_idx] && mres.timed_out)
                    begin
                        ctrl.clr_wait   = 1'b1;
                        ctrl.clr_addr   = slot_idx;
                        res_next.status = ST_IDLE;
                    end
                    else if (waiting[slot_idx])
                    begin
                        res_next.status = ST_WAITING;
                    end
                    else
                    begin
                        res_next.status = ST_IDLE;
                    end
                end
                else
                begin
                    // Packet scan: one slot record per cycle.
                    if (waiting[scan_idx] && mres.hit)
                    begin
                        ctrl.clr_wait           = 1'b1;
                        ctrl.clr_addr           = scan_idx;
                        res_next.status         = ST_MATCHED;
                        res_next.hit_slot       = 3'(idx_reg);
                        res_next.xfer_len       = mres.xfer_len;
                        res_next.from_addr_high = item_reg.addr_high;
                        res_next.from_addr_low  = item_reg.addr_low;
                        res_next.from_port      = item_reg.src_port;
                        state_next              = S_DONE;
                    end
                    else if (idx_inc == limit_reg)
                    begin
                        res_next.status = ST_MISSED;
                        state_next      = S_DONE;
                    end
                    else
                    begin
                        idx_next     = idx_inc;
                        ctrl.rd_en   = 1'b1;
                        ctrl.rd_addr = idx_inc[SLOT_W-1:0];
                    end
                end
            end

            S_DONE:
            begin
                if (!rsp_valid_reg || rsp_ready)
                begin
                    rsp_next       = res_reg;
                    rsp_valid_next = 1'b1;
                    state_next     = S_IDLE;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            rsp_valid_reg <= 1'b0;
            active_reg    <= ACTIVE_RST;
            idx_reg       <= '0;
            limit_reg     <= '0;
        end
        else
        begin
            state_reg     <= state_next;
            rsp_valid_reg <= rsp_valid_next;
            idx_reg       <= idx_next;
            limit_reg     <= limit_next;
            if (cfg_we)
            begin
                active_reg <= cfg_wdata;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        item_reg <= item_next;
        res_reg  <= res_next;
        rsp_reg  <= rsp_next;
    end

    // The packet scan never runs past the clamped scan count.
    a_scan_bound: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_EVAL && item_reg.cmd == CMD_PKT) |-> (idx_reg < limit_reg))
        else $error("packet scan index beyond scan count");

    // A matched slot is no longer waiting afterwards.
    a_match_clears: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_EVAL && item_reg.cmd == CMD_PKT && waiting[scan_idx] && mres.hit)
        |=> !waiting[$past(scan_idx)])
        else $error("matched slot still waiting");

    // An arm of a valid slot leaves that slot waiting.
    a_arm_sets: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_DISPATCH && item_reg.cmd == CMD_ARM && slot_ok)
        |=> waiting[$past(slot_idx)])
        else $error("armed slot not waiting");

    // A finished result waits while the output register is still occupied.
    a_done_holds: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_DONE && rsp_valid_reg && !rsp_ready) |=> (state_reg == S_DONE))
        else $error("result overwrote a pending output item");

endmodule
